>>> hdl/rsfr_pkg.sv
package rsfr_pkg;

   // frame geometry
   localparam int CHANNEL_COUNT     = 16;
   localparam int MAX_CHANNEL_FRAME = 40;
   localparam int MAX_REQUEST_FRAME = 9;
   localparam int HEADER_BYTES      = 6;

   // storage sizes and field widths
   localparam int STORE_DEPTH = 64;
   localparam int STORE_AW    = 6;
   localparam int POS_W       = 6;
   localparam int CH_IDX_W    = 4;
   localparam int CH_VAL_W    = 13;
   localparam int GAP_W       = 16;

   // byte codes
   localparam logic [7:0]  START_CHANNEL    = 8'h3E;
   localparam logic [7:0]  START_REQUEST    = 8'h3D;
   localparam logic [15:0] TYPE_CHANNEL     = 16'h3E03;
   localparam logic [15:0] TYPE_CHANNEL_REQ = 16'h3E01;
   localparam logic [15:0] CRC_POLY         = 16'h8408;
   localparam logic [15:0] GAP_RESET        = 16'd1000;

   typedef enum logic [1:0] {
      KIND_IDLE,
      KIND_CHANNEL,
      KIND_REQUEST
   } frame_kind_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVENT,
      S_RD_LO,
      S_RD_HI,
      S_LOAD
   } seq_state_type;

   // framer to sequencer: frame store write and frame end events
   typedef struct packed {
      logic                fs_we;
      logic [STORE_AW-1:0] fs_addr;
      logic [7:0]          fs_data;
      logic                chan_done;
      logic                chan_update;
      logic                req_done;
   } framer_out_type;

   // reflected crc-16, one byte, lsb first
   function automatic logic [15:0] crc_update(input logic [15:0] crc_i,
                                              input logic [7:0]  data_i);
      logic [15:0] c;
      c = crc_i ^ {8'h00, data_i};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> hdl/rsfr_ram.sv
module rsfr_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/rsfr_framer.sv
module rsfr_framer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             rx_byte,
   input  logic [15:0]            gap_us,
   input  logic                   csr_wr_en,
   input  logic [15:0]            csr_wr_data,
   output rsfr_pkg::framer_out_type fr_out
);
   import rsfr_pkg::*;

   logic [GAP_W-1:0] min_gap_ff, min_gap_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] len_ff, len_in;
   frame_kind_type   kind_ff, kind_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       type_byte_ff, type_byte_in;
   logic [7:0]       len_byte_ff, len_byte_in;

   logic             gap_restart;
   logic [POS_W-1:0] pos_base, len_base, pos_next, len_cur;
   frame_kind_type   kind_base, kind_cur;
   logic [15:0]      crc_base, crc_next;
   logic [7:0]       max_len;
   logic             take, hdr_bad, ends;

   // framing state
   always_ff @(posedge clock) begin
      if (reset) begin
         min_gap_ff <= GAP_RESET;
         pos_ff     <= '0;
         len_ff     <= POS_W'(MAX_CHANNEL_FRAME);
         kind_ff    <= KIND_IDLE;
         crc_ff     <= '0;
      end else begin
         min_gap_ff <= min_gap_in;
         pos_ff     <= pos_in;
         len_ff     <= len_in;
         kind_ff    <= kind_in;
         crc_ff     <= crc_in;
      end
   end

   // header bytes kept for the length and type checks
   always_ff @(posedge clock) begin
      type_byte_ff <= type_byte_in;
      len_byte_ff  <= len_byte_in;
   end

   // per-byte framing
   always_comb begin
      min_gap_in = csr_wr_en ? csr_wr_data : min_gap_ff;

      // long idle gap drops any partial frame
      gap_restart = gap_us > min_gap_ff;
      pos_base    = gap_restart ? '0 : pos_ff;
      len_base    = gap_restart ? POS_W'(MAX_CHANNEL_FRAME) : len_ff;
      kind_base   = gap_restart ? KIND_IDLE : kind_ff;

      take = accept && ((pos_base != '0) || (rx_byte == START_CHANNEL) ||
                        (rx_byte == START_REQUEST));

      if (pos_base == '0) begin
         kind_cur = (rx_byte == START_CHANNEL) ? KIND_CHANNEL : KIND_REQUEST;
         crc_base = '0;
      end else begin
         kind_cur = kind_base;
         crc_base = crc_ff;
      end

      crc_next = crc_update(crc_base, rx_byte);
      pos_next = pos_base + POS_W'(1);
      max_len  = (kind_cur == KIND_CHANNEL) ? 8'(MAX_CHANNEL_FRAME) : 8'(MAX_REQUEST_FRAME);

      // length check once the header is in
      hdr_bad = (pos_next == POS_W'(HEADER_BYTES)) &&
                ((len_byte_ff > max_len) || (len_byte_ff < 8'(HEADER_BYTES)));
      len_cur = (pos_next == POS_W'(HEADER_BYTES)) ? len_byte_ff[POS_W-1:0] : len_base;
      ends    = !hdr_bad && (pos_next == len_cur);

      pos_in       = pos_ff;
      len_in       = len_ff;
      kind_in      = kind_ff;
      crc_in       = crc_ff;
      type_byte_in = type_byte_ff;
      len_byte_in  = len_byte_ff;

      if (accept) begin
         pos_in  = pos_base;
         len_in  = len_base;
         kind_in = kind_base;
      end
      if (take) begin
         kind_in = kind_cur;
         crc_in  = crc_next;
         pos_in  = pos_next;
         len_in  = len_cur;
         if (pos_base == POS_W'(1)) begin
            type_byte_in = rx_byte;
         end
         if (pos_base == POS_W'(2)) begin
            len_byte_in = rx_byte;
         end
         if (hdr_bad || ends) begin
            pos_in  = '0;
            len_in  = POS_W'(MAX_CHANNEL_FRAME);
            kind_in = KIND_IDLE;
         end
      end

      fr_out.fs_we       = take;
      fr_out.fs_addr     = STORE_AW'(pos_base);
      fr_out.fs_data     = rx_byte;
      fr_out.chan_done   = take && ends && (kind_cur == KIND_CHANNEL) && (crc_next == '0);
      fr_out.req_done    = take && ends && (kind_cur == KIND_REQUEST);
      fr_out.chan_update = ({START_CHANNEL, type_byte_ff} == TYPE_CHANNEL) ||
                           ({START_CHANNEL, type_byte_ff} == TYPE_CHANNEL_REQ);
   end

endmodule

>>> hdl/rc_serial_frame_receiver.sv
// Serial frame receiver for an RC link.
// Input channel (req_*): one beat per received UART byte with the idle gap
// before it in microseconds. A byte that does not finish a frame leaves
// req_ready high for the next byte.
// Result channel (rsp_*): a finished request frame gives one beat with
// rsp_kind high. A finished channel frame with a good crc gives 16 beats,
// channel 0 to 15, rsp_last on the final one. A bad crc gives nothing.
// Channel frames of type 0x01 or 0x03 refresh the stored channel values
// before they are sent; other types resend the stored values.
// The frame store RAM has one read port, so each channel result steps through a
// low byte read, a high byte read and a load that refreshes the channel store
// on an update and sends the value. A request event goes from its byte through
// the S_EVENT state to the output register. req_ready is low while results of
// a byte are still being produced; a beat waiting in the output register does
// not block a byte that completes no frame. A stall on rsp_ready holds the
// sequence without loss. csr_wr_en/csr_wr_data set the frame restart gap,
// written only while idle by the user; the block does not enforce it.
// Reset (synchronous): framing returns to idle, gap threshold 1000, frame
// and channel stores read as zero until written.
module rc_serial_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic [15:0] req_gap_us,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [3:0]  rsp_channel_index,
   output logic [12:0] rsp_channel_value,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import rsfr_pkg::*;

   framer_out_type fr_out;
   seq_state_type  state_ff, state_in;

   logic                   accept;
   logic                   out_free;
   logic [CH_IDX_W-1:0]    idx_ff, idx_in;
   logic                   update_ff, update_in;
   logic [STORE_DEPTH-1:0] fs_valid_ff, fs_valid_in;
   logic [CHANNEL_COUNT-1:0] ch_valid_ff, ch_valid_in;
   logic                   fs_rd_valid_ff, fs_rd_valid_in;
   logic                   ch_rd_valid_ff, ch_rd_valid_in;
   logic [7:0]             lo_byte_ff, lo_byte_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   logic [CH_IDX_W-1:0]    rsp_idx_ff, rsp_idx_in;
   logic [CH_VAL_W-1:0]    rsp_val_ff, rsp_val_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   fs_rd_en;
   logic [STORE_AW-1:0]    fs_rd_addr, lo_addr;
   logic [7:0]             fs_rd_data, hi_byte;
   logic [15:0]            ch_word;
   logic                   ch_rd_en, ch_wr_en;
   logic [CH_VAL_W-1:0]    ch_rd_data, ch_value;
   logic                   idx_last;

   assign accept = req_valid && req_ready;

   rsfr_framer u_framer (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .rx_byte     (req_rx_byte),
      .gap_us      (req_gap_us),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fr_out      (fr_out)
   );

   // received frame bytes
   rsfr_ram #(.DATA_W(8), .DEPTH(STORE_DEPTH)) u_frame_ram (
      .clock   (clock),
      .wr_en   (fr_out.fs_we),
      .wr_addr (fr_out.fs_addr),
      .wr_data (fr_out.fs_data),
      .rd_en   (fs_rd_en),
      .rd_addr (fs_rd_addr),
      .rd_data (fs_rd_data)
   );

   // stored channel values
   rsfr_ram #(.DATA_W(CH_VAL_W), .DEPTH(CHANNEL_COUNT)) u_chan_ram (
      .clock   (clock),
      .wr_en   (ch_wr_en),
      .wr_addr (idx_ff),
      .wr_data (ch_value),
      .rd_en   (ch_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ch_rd_data)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fs_valid_ff  <= '0;
         ch_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fs_valid_ff  <= fs_valid_in;
         ch_valid_ff  <= ch_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // sequencer and output payload
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      update_ff      <= update_in;
      fs_rd_valid_ff <= fs_rd_valid_in;
      ch_rd_valid_ff <= ch_rd_valid_in;
      lo_byte_ff     <= lo_byte_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_val_ff     <= rsp_val_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // result sequencer
   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      req_ready = (state_ff == S_IDLE);
      idx_last  = (idx_ff == CH_IDX_W'(CHANNEL_COUNT - 1));

      lo_addr    = STORE_AW'(HEADER_BYTES) + STORE_AW'({idx_ff, 1'b0});
      fs_rd_addr = lo_addr;
      fs_rd_en   = 1'b0;
      ch_rd_en   = 1'b0;
      ch_wr_en   = 1'b0;

      // unwritten entries read as zero
      hi_byte  = fs_rd_valid_ff ? fs_rd_data : 8'h00;
      ch_word  = {hi_byte, lo_byte_ff};
      ch_value = update_ff ? ch_word[15:3]
                           : (ch_rd_valid_ff ? ch_rd_data : '0);

      state_in       = state_ff;
      idx_in         = idx_ff;
      update_in      = update_ff;
      fs_rd_valid_in = fs_rd_valid_ff;
      ch_rd_valid_in = ch_rd_valid_ff;
      lo_byte_in     = lo_byte_ff;
      ch_valid_in    = ch_valid_ff;
      fs_valid_in    = fs_valid_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_last_in  = rsp_last_ff;

      if (fr_out.fs_we) begin
         fs_valid_in[fr_out.fs_addr] = 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            if (fr_out.req_done) begin
               state_in = S_EVENT;
            end else if (fr_out.chan_done) begin
               state_in  = S_RD_LO;
               idx_in    = '0;
               update_in = fr_out.chan_update;
            end
         end
         S_EVENT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = 1'b1;
               rsp_idx_in   = '0;
               rsp_val_in   = '0;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_RD_LO: begin
            // low byte and stored value for this channel
            fs_rd_en       = 1'b1;
            fs_rd_addr     = lo_addr;
            fs_rd_valid_in = fs_valid_ff[lo_addr];
            ch_rd_en       = 1'b1;
            ch_rd_valid_in = ch_valid_ff[idx_ff];
            state_in       = S_RD_HI;
         end
         S_RD_HI: begin
            lo_byte_in     = fs_rd_valid_ff ? fs_rd_data : 8'h00;
            fs_rd_en       = 1'b1;
            fs_rd_addr     = lo_addr + STORE_AW'(1);
            fs_rd_valid_in = fs_valid_ff[lo_addr + STORE_AW'(1)];
            state_in       = S_LOAD;
         end
         S_LOAD: begin
            if (out_free) begin
               // refresh the channel store on an update and send the value
               ch_wr_en = update_ff;
               if (update_ff) begin
                  ch_valid_in[idx_ff] = 1'b1;
               end
               rsp_valid_in = 1'b1;
               rsp_kind_in  = 1'b0;
               rsp_idx_in   = idx_ff;
               rsp_val_in   = ch_value;
               rsp_last_in  = idx_last;
               if (idx_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + CH_IDX_W'(1);
                  state_in = S_RD_LO;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_channel_index = rsp_idx_ff;
   assign rsp_channel_value = rsp_val_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

>>> tb/rsfr_frame_checker.sv
`timescale 1ns / 100ps

package rsfr_tb_pkg;

   // crc-16 with reflected polynomial 0x8408, fed one data bit at a time
   function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                            input logic [7:0]  data_in);
      logic [15:0] c;
      logic        fb;
      c = crc_in;
      for (int k = 0; k < 8; k++) begin
         fb = c[0] ^ data_in[k];
         c  = c >> 1;
         if (fb) begin
            c = c ^ 16'h8408;
         end
      end
      return c;
   endfunction

endpackage

module rsfr_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic [15:0] req_gap_us,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_kind,
   input  logic [3:0]  rsp_channel_index,
   input  logic [12:0] rsp_channel_value,
   input  logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output int          mismatches,
   output int          outstanding
);

   import rsfr_pkg::*;
   import rsfr_tb_pkg::*;

   typedef struct packed {
      logic        kind;
      logic [3:0]  idx;
      logic [12:0] val;
      logic        last;
   } beat_type;

   // expected result beats, oldest first
   beat_type       due_beats [$];
   beat_type       want;

   // predictor state
   logic [15:0]    gap_limit;
   logic [5:0]     pos;
   logic [5:0]     flen;
   frame_kind_type fkind;
   logic [15:0]    crc;
   logic [7:0]     fstore [0:STORE_DEPTH-1];
   logic [12:0]    chstore [0:CHANNEL_COUNT-1];
   int             n_bad = 0;

   task automatic flag_mismatch(input string what);
      $display("%0t ns rsfr check: %s", $time, what);
      n_bad++;
   endtask

   task automatic drop_frame();
      pos   = '0;
      flen  = 6'(MAX_CHANNEL_FRAME);
      fkind = KIND_IDLE;
   endtask

   // one received byte: framing, crc, and the beats a finished frame gives
   task automatic decode_byte(input logic [7:0] b, input logic [15:0] g);
      logic [5:0]  a;
      logic [15:0] w;
      logic        live;
      int          maxlen;
      beat_type    nb;
      if (g > gap_limit) begin
         drop_frame();
      end
      live = 1'b1;
      if (pos == 0) begin
         if (b == START_CHANNEL) begin
            fkind = KIND_CHANNEL;
            crc   = '0;
         end else if (b == START_REQUEST) begin
            fkind = KIND_REQUEST;
            crc   = '0;
         end else begin
            live = 1'b0;
         end
      end
      if (live) begin
         fstore[pos] = b;
         crc         = crc_fold(crc, b);
         pos         = pos + 6'd1;
         // header complete: length byte must fit the frame kind
         if (pos == HEADER_BYTES) begin
            maxlen = (fkind == KIND_CHANNEL) ? MAX_CHANNEL_FRAME : MAX_REQUEST_FRAME;
            if (fstore[2] > maxlen || fstore[2] < HEADER_BYTES) begin
               drop_frame();
               live = 1'b0;
            end else begin
               flen = fstore[2][5:0];
            end
         end
      end
      if (live && pos == flen) begin
         if (fkind == KIND_CHANNEL && crc == 16'h0000) begin
            // refresh channel values for the two known frame types
            if ({fstore[0], fstore[1]} == TYPE_CHANNEL ||
                {fstore[0], fstore[1]} == TYPE_CHANNEL_REQ) begin
               for (int i = 0; i < CHANNEL_COUNT; i++) begin
                  a          = 6'(HEADER_BYTES + 2 * i);
                  w          = {fstore[a + 6'd1], fstore[a]};
                  chstore[i] = w[15:3];
               end
            end
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
               nb.kind = 1'b0;
               nb.idx  = 4'(i);
               nb.val  = chstore[i];
               nb.last = (i == CHANNEL_COUNT - 1);
               due_beats.push_back(nb);
            end
         end else if (fkind == KIND_REQUEST) begin
            nb.kind = 1'b1;
            nb.idx  = '0;
            nb.val  = '0;
            nb.last = 1'b1;
            due_beats.push_back(nb);
         end
         drop_frame();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         gap_limit = GAP_RESET;
         crc       = '0;
         for (int i = 0; i < STORE_DEPTH; i++) begin
            fstore[i] = '0;
         end
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            chstore[i] = '0;
         end
         drop_frame();
         due_beats.delete();
      end else begin
         // result beat against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (due_beats.size() == 0) begin
               flag_mismatch($sformatf("unexpected beat kind %0d ch %0d value %0d last %0d",
                                       rsp_kind, rsp_channel_index, rsp_channel_value,
                                       rsp_last));
            end else begin
               want = due_beats.pop_front();
               if (rsp_kind !== want.kind) begin
                  flag_mismatch($sformatf("kind %0d, expected %0d", rsp_kind, want.kind));
               end
               if (rsp_channel_index !== want.idx) begin
                  flag_mismatch($sformatf("channel index %0d, expected %0d",
                                          rsp_channel_index, want.idx));
               end
               if (rsp_channel_value !== want.val) begin
                  flag_mismatch($sformatf("channel %0d value %0d, expected %0d",
                                          want.idx, rsp_channel_value, want.val));
               end
               if (rsp_last !== want.last) begin
                  flag_mismatch($sformatf("channel %0d last %0d, expected %0d",
                                          want.idx, rsp_last, want.last));
               end
            end
         end
         if (csr_wr_en) begin
            gap_limit = csr_wr_data;
         end
         if (req_valid && req_ready) begin
            decode_byte(req_rx_byte, req_gap_us);
         end
      end
      mismatches  <= n_bad;
      outstanding <= due_beats.size();
   end

endmodule

>>> tb/tb_rc_serial_frame_receiver.sv
`timescale 1ns / 100ps

module tb_rc_serial_frame_receiver;

   import rsfr_pkg::*;
   import rsfr_tb_pkg::*;

   typedef enum int {
      TAIL_RANDOM,
      TAIL_GOOD_CRC,
      TAIL_BAD_CRC
   } tail_mode_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = '0;
   logic [15:0] req_gap_us  = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic        rsp_kind;
   logic [3:0]  rsp_channel_index;
   logic [12:0] rsp_channel_value;
   logic        rsp_last;
   logic        csr_wr_en   = 1'b0;
   logic [15:0] csr_wr_data = '0;

   int          mismatches;
   int          outstanding;

   // stimulus state
   logic [15:0] gap_cur     = GAP_RESET;
   logic        idle_on     = 1'b1;
   logic        stall_on    = 1'b1;
   logic [7:0]  frm [0:MAX_CHANNEL_FRAME-1];
   int          frm_n;
   int          frame_bytes = 0;

   always #5 clock = ~clock;

   rc_serial_frame_receiver i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .req_gap_us        (req_gap_us),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_last          (rsp_last),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   rsfr_frame_checker i_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .req_gap_us        (req_gap_us),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_last          (rsp_last),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .mismatches        (mismatches),
      .outstanding       (outstanding)
   );

   // result side back-pressure
   always @(posedge clock) begin
      rsp_ready <= !stall_on || ($urandom_range(99) >= 7);
   end

   // gap that keeps the current frame going
   function automatic logic [15:0] calm_gap();
      int r;
      r = $urandom_range(9);
      if (r == 0) begin
         return gap_cur;
      end
      if (r < 4) begin
         return 16'($urandom_range(0, gap_cur));
      end
      return 16'($urandom_range(0, (gap_cur < 50) ? gap_cur : 50));
   endfunction

   // gap that restarts framing, or a calm gap when none can exceed the threshold
   function automatic logic [15:0] break_gap();
      int r;
      if (gap_cur == 16'hFFFF) begin
         return calm_gap();
      end
      r = $urandom_range(9);
      if (r == 0) begin
         return gap_cur + 16'd1;
      end
      if (r == 1) begin
         return 16'hFFFF;
      end
      return 16'($urandom_range(gap_cur + 1, 65535));
   endfunction

   function automatic logic [7:0] chan_len();
      if ($urandom_range(4) == 0) begin
         return 8'(MAX_CHANNEL_FRAME);
      end
      return 8'($urandom_range(HEADER_BYTES, MAX_CHANNEL_FRAME));
   endfunction

   function automatic logic [7:0] bad_len(input int maxl);
      if ($urandom_range(1) == 1) begin
         return 8'($urandom_range(maxl + 1, 255));
      end
      return 8'($urandom_range(0, HEADER_BYTES - 1));
   endfunction

   function automatic logic [7:0] chan_type();
      int r;
      r = $urandom_range(9);
      if (r < 4) begin
         return TYPE_CHANNEL[7:0];
      end
      if (r < 8) begin
         return TYPE_CHANNEL_REQ[7:0];
      end
      return 8'($urandom);
   endfunction

   // channel frame; a bad length sends only the header
   task automatic make_chan(input logic [7:0] len_b, input logic [7:0] tp,
                            input tail_mode_type tail);
      logic [15:0] c;
      logic        ok_len;
      ok_len = (len_b >= HEADER_BYTES && len_b <= MAX_CHANNEL_FRAME);
      frm_n  = ok_len ? int'(len_b) : HEADER_BYTES;
      frm[0] = START_CHANNEL;
      frm[1] = tp;
      frm[2] = len_b;
      for (int i = 3; i < frm_n; i++) begin
         frm[i] = 8'($urandom);
      end
      // crc appended low byte first leaves a zero residue
      if (ok_len && tail != TAIL_RANDOM) begin
         c = '0;
         for (int i = 0; i < frm_n - 2; i++) begin
            c = crc_fold(c, frm[i]);
         end
         frm[frm_n - 2] = c[7:0];
         frm[frm_n - 1] = c[15:8];
         if (tail == TAIL_BAD_CRC) begin
            frm[frm_n - 1] = frm[frm_n - 1] ^ 8'($urandom_range(1, 255));
         end
      end
   endtask

   task automatic make_req(input logic [7:0] len_b);
      frm_n  = (len_b >= HEADER_BYTES && len_b <= MAX_REQUEST_FRAME) ? int'(len_b)
                                                                     : HEADER_BYTES;
      frm[0] = START_REQUEST;
      frm[1] = 8'($urandom);
      frm[2] = len_b;
      for (int i = 3; i < frm_n; i++) begin
         frm[i] = 8'($urandom);
      end
   endtask

   // one input beat, with a random idle ahead of it
   task automatic send_byte(input logic [7:0] b, input logic [15:0] g);
      while (idle_on && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      req_gap_us  <= g;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      frame_bytes++;
   endtask

   // frame bytes, now and then broken by a restart gap
   task automatic send_frame();
      logic [15:0] g;
      for (int i = 0; i < frm_n; i++) begin
         if (i == 0) begin
            g = ($urandom_range(3) == 0) ? break_gap() : calm_gap();
         end else begin
            g = ($urandom_range(49) == 0) ? break_gap() : calm_gap();
         end
         send_byte(frm[i], g);
      end
   endtask

   // hold off the sender until every expected beat is back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_gap(input logic [15:0] v);
      settle();
      repeat (60) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      gap_cur = v;
   endtask

   task automatic run_random(input int quota);
      int stop_at;
      int pick;
      stop_at = frame_bytes + quota;
      while (frame_bytes < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            make_chan(chan_len(), chan_type(), TAIL_GOOD_CRC);
         end else if (pick < 60) begin
            make_chan(chan_len(), chan_type(), TAIL_BAD_CRC);
         end else if (pick < 65) begin
            make_chan(chan_len(), chan_type(), TAIL_RANDOM);
         end else if (pick < 70) begin
            make_chan(bad_len(MAX_CHANNEL_FRAME), chan_type(), TAIL_GOOD_CRC);
         end else if (pick < 85) begin
            make_req(8'($urandom_range(HEADER_BYTES, MAX_REQUEST_FRAME)));
         end else if (pick < 90) begin
            make_req(bad_len(MAX_REQUEST_FRAME));
         end
         if (pick < 90) begin
            send_frame();
         end else begin
            // line noise between frames
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom), calm_gap());
         end
         if ($urandom_range(11) == 0) begin
            settle();
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, both frame kinds, drops
      send_byte(8'hFF, 16'hFFFF);
      send_byte(8'h00, 16'h0000);
      make_req(8'(HEADER_BYTES));
      send_frame();
      make_chan(8'd8, TYPE_CHANNEL[7:0], TAIL_GOOD_CRC);
      send_frame();
      make_chan(8'(HEADER_BYTES), TYPE_CHANNEL_REQ[7:0], TAIL_BAD_CRC);
      send_frame();
      make_chan(8'(MAX_CHANNEL_FRAME + 1), TYPE_CHANNEL_REQ[7:0], TAIL_RANDOM);
      send_frame();
      make_req(8'(HEADER_BYTES - 1));
      send_frame();

      // random at the reset threshold
      run_random(35);

      // widest threshold, no idling on either side
      write_gap(16'hFFFF);
      idle_on  = 1'b0;
      stall_on = 1'b0;
      run_random(35);

      // zero threshold: any nonzero gap restarts
      write_gap(16'h0000);
      idle_on  = 1'b1;
      stall_on = 1'b1;
      run_random(35);

      write_gap(16'($urandom_range(1, 65534)));
      run_random(40);

      settle();
      repeat (60) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_rc_serial_frame_receiver: PASS");
      end else begin
         $display("tb_rc_serial_frame_receiver: FAIL");
      end
      $finish;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("tb_rc_serial_frame_receiver: FAIL");
      $finish;
   end

endmodule
